### rtl/tws_pkg.sv
// Shared types and command codes for the time window skip table.
package tws_pkg;

  localparam int ID_W   = 32;
  localparam int TIME_W = 32;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   slot_id;
    logic [TIME_W-1:0] win_start;
    logic [TIME_W-1:0] win_end;
  } slot_t;

  // take: this slot ends the scan (set target or clear target)
  typedef struct packed {
    logic take;
    logic hit;
  } eval_t;

endpackage

### rtl/tws_slot_eval.sv
// Per-slot decision for one command against one table entry.
module tws_slot_eval (
  input  logic [tws_pkg::CMD_W-1:0]  cmd,
  input  logic [tws_pkg::ID_W-1:0]   sched_id,
  input  logic [tws_pkg::TIME_W-1:0] time_now,
  input  tws_pkg::slot_t             slot,
  input  logic                       is_last,
  output tws_pkg::eval_t             ev
);

  logic id_eq;
  logic in_win;

  assign id_eq  = (slot.slot_id == sched_id);
  assign in_win = (time_now >= slot.win_start) && (time_now < slot.win_end);

  always_comb begin
    ev = '0;
    unique case (cmd)
      tws_pkg::CMD_SET: begin
        ev.take = id_eq || (slot.slot_id == '0) || is_last;
      end
      tws_pkg::CMD_CHECK: begin
        ev.hit = id_eq && in_win;
      end
      tws_pkg::CMD_CLEAR: begin
        ev.take = id_eq;
      end
      default: begin
        ev = '0;
      end
    endcase
  end

endmodule

### rtl/time_window_skip_table_unit.sv
// Top level of the time window skip table: command intake, table memory and scan.
// Each command word yields one result word. A set with an invalid window and the
// unused command skip the scan and go straight to the done state. Every other command
// scans the table one entry a cycle through the single read port of the slot
// memory; a set or clear stops the scan at the entry it takes. The next word can be
// taken once the result is raised. A result held by the receiver keeps the next
// result in the done state, which stalls the input for as long as it waits.
// Entries are cleared at reset at once by per-entry valid bits; an entry never
// written reads as empty.
module time_window_skip_table_unit #(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // sched_id, window_start, window_end, time_now
  input  logic [1:0]   s_tuser,  // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata   // hit, zero fill
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;

  // latched command word
  logic [tws_pkg::CMD_W-1:0]  cmd;
  logic [tws_pkg::ID_W-1:0]   sched_id;
  logic [tws_pkg::TIME_W-1:0] window_start;
  logic [tws_pkg::TIME_W-1:0] window_end;
  logic [tws_pkg::TIME_W-1:0] time_now;

  tws_pkg::slot_t mem [ENTRIES];
  tws_pkg::slot_t rd_data;
  logic [ENTRIES-1:0] vld;

  logic [IDX_W-1:0] issue_idx;
  logic             issue_done;
  logic [IDX_W-1:0] eval_idx;
  logic             eval_vld;
  logic             chk_acc;
  logic             res_hit;

  tws_pkg::slot_t slot;
  tws_pkg::eval_t ev;
  logic           finish;
  logic           mem_re;
  logic           set_we;
  logic           clr_we;
  logic           in_acc;
  logic           win_ok;
  logic [tws_pkg::CMD_W-1:0] in_cmd;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_cmd   = s_tuser;
  assign win_ok   = (s_tdata[63:32] != '0) && (s_tdata[95:64] != '0)
                    && (s_tdata[95:64] > s_tdata[63:32]);

  // never-written entries read as empty
  assign slot = vld[eval_idx] ? rd_data : '0;

  tws_slot_eval u_eval (
    .cmd      (cmd),
    .sched_id (sched_id),
    .time_now (time_now),
    .slot     (slot),
    .is_last  (eval_idx == LAST),
    .ev       (ev)
  );

  assign finish = (state == ST_SCAN) && eval_vld && (ev.take || (eval_idx == LAST));
  assign mem_re = (state == ST_SCAN) && !issue_done && !finish;
  assign set_we = finish && ev.take && (cmd == tws_pkg::CMD_SET);
  assign clr_we = finish && ev.take && (cmd == tws_pkg::CMD_CLEAR);

  always_ff @(posedge clk) begin
    if (set_we) begin
      mem[eval_idx] <= '{slot_id: sched_id, win_start: window_start, win_end: window_end};
    end
    if (mem_re) begin
      rd_data <= mem[issue_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd          <= in_cmd;
      sched_id     <= s_tdata[31:0];
      window_start <= s_tdata[63:32];
      window_end   <= s_tdata[95:64];
      time_now     <= s_tdata[127:96];
    end
    if (mem_re) begin
      eval_idx <= issue_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      vld        <= '0;
      issue_idx  <= '0;
      issue_done <= 1'b0;
      eval_vld   <= 1'b0;
      chk_acc    <= 1'b0;
      res_hit    <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      if (set_we) begin
        vld[eval_idx] <= 1'b1;
      end
      if (clr_we) begin
        vld[eval_idx] <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            issue_idx  <= '0;
            issue_done <= 1'b0;
            eval_vld   <= 1'b0;
            chk_acc    <= 1'b0;
            res_hit    <= 1'b0;
            if ((in_cmd == tws_pkg::CMD_UNUSED) || ((in_cmd == tws_pkg::CMD_SET) && !win_ok)) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (finish) begin
            state    <= ST_DONE;
            eval_vld <= 1'b0;
            priority if (cmd == tws_pkg::CMD_SET) begin
              res_hit <= 1'b1;
            end else if (cmd == tws_pkg::CMD_CLEAR) begin
              res_hit <= ev.take;
            end else begin
              res_hit <= chk_acc || ev.hit;
            end
          end else begin
            if (eval_vld) begin
              chk_acc <= chk_acc || ev.hit;
            end
            eval_vld <= mem_re;
            if (mem_re) begin
              issue_idx  <= issue_idx + 1'b1;
              issue_done <= (issue_idx == LAST);
            end
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, res_hit};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // table is only written from a slot that was just read in a scan
  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (set_we || clr_we) |-> (state == ST_SCAN) && eval_vld)
    else $error("table write outside a scan");

  a_clear_drops: assert property (@(posedge clk) disable iff (rst)
    clr_we |=> !vld[$past(eval_idx)])
    else $error("cleared entry still valid");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_SCAN) || (state == ST_DONE))
    else $error("accepted word not started");

  a_idle_no_eval: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !eval_vld)
    else $error("stale scan data while idle");

endmodule

### tb/testbench.sv
// Self-checking testbench for the time window skip table: directed table, then random traffic.
`timescale 1ns / 100ps

module testbench;

  localparam int ID_W   = tws_pkg::ID_W;
  localparam int TIME_W = tws_pkg::TIME_W;
  localparam int CMD_W  = tws_pkg::CMD_W;

  localparam logic [CMD_W-1:0] CMD_SET    = tws_pkg::CMD_SET;
  localparam logic [CMD_W-1:0] CMD_CHECK  = tws_pkg::CMD_CHECK;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = tws_pkg::CMD_CLEAR;
  localparam logic [CMD_W-1:0] CMD_UNUSED = tws_pkg::CMD_UNUSED;

  localparam int ENTRIES    = 16;
  localparam int ID_POOL    = 24;
  localparam int RAND_ITEMS = 1950;
  localparam int QUIET_MAX  = 2000;
  localparam int DRAIN      = 40;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] ws;
    logic [TIME_W-1:0] we;
    logic [TIME_W-1:0] now;
    logic              known;  // hit below is typed in, else taken from the table model
    logic              hit;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty table
    '{CMD_CHECK,  32'd1,        32'd0,        32'd0,        32'd5,        1'b1, 1'b0},
    '{CMD_CLEAR,  32'd1,        32'd0,        32'd0,        32'd0,        1'b1, 1'b0},
    '{CMD_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0},
    // malformed windows are refused, then id 1 gets the window [10, 20)
    '{CMD_SET,    32'd1,        32'd0,        32'd10,       32'd0,        1'b1, 1'b0},
    '{CMD_SET,    32'd1,        32'd10,       32'd0,        32'd0,        1'b1, 1'b0},
    '{CMD_SET,    32'd1,        32'd10,       32'd10,       32'd0,        1'b1, 1'b0},
    '{CMD_SET,    32'd1,        32'd20,       32'd10,       32'd0,        1'b1, 1'b0},
    '{CMD_SET,    32'd1,        32'd10,       32'd20,       32'd0,        1'b1, 1'b1},
    // window edges: start inclusive, end exclusive
    '{CMD_CHECK,  32'd1,        32'd0,        32'd0,        32'd9,        1'b1, 1'b0},
    '{CMD_CHECK,  32'd1,        32'd0,        32'd0,        32'd10,       1'b1, 1'b1},
    '{CMD_CHECK,  32'd1,        32'd0,        32'd0,        32'd19,       1'b1, 1'b1},
    '{CMD_CHECK,  32'd1,        32'd0,        32'd0,        32'd20,       1'b1, 1'b0},
    '{CMD_SET,    32'hFFFFFFFF, 32'd1,        32'hFFFFFFFF, 32'd0,        1'b1, 1'b1},
    '{CMD_CHECK,  32'hFFFFFFFF, 32'd0,        32'd0,        32'hFFFFFFFE, 1'b1, 1'b1},
    '{CMD_CHECK,  32'hFFFFFFFF, 32'd0,        32'd0,        32'hFFFFFFFF, 1'b1, 1'b0},
    '{CMD_CHECK,  32'hFFFFFFFF, 32'd0,        32'd0,        32'd0,        1'b1, 1'b0},
    // id zero lands in an empty slot; the slot keeps id zero, so it still counts as free
    '{CMD_SET,    32'd0,        32'd100,      32'd200,      32'd0,        1'b0, 1'b0},
    '{CMD_CHECK,  32'd0,        32'd0,        32'd0,        32'd150,      1'b0, 1'b0},
    '{CMD_CHECK,  32'd0,        32'd0,        32'd0,        32'd0,        1'b0, 1'b0},
    '{CMD_CLEAR,  32'd0,        32'd0,        32'd0,        32'd0,        1'b0, 1'b0},
    // same id overwrites its own slot
    '{CMD_SET,    32'd1,        32'd30,       32'd40,       32'd0,        1'b0, 1'b0},
    '{CMD_CHECK,  32'd1,        32'd0,        32'd0,        32'd15,       1'b0, 1'b0},
    '{CMD_CLEAR,  32'd1,        32'd0,        32'd0,        32'd0,        1'b0, 1'b0},
    '{CMD_CLEAR,  32'd1,        32'd0,        32'd0,        32'd0,        1'b0, 1'b0}
  };

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // sched_id, window_start, window_end, time_now
  logic [1:0]   s_tuser;   // cmd
  logic         m_tvalid;
  logic         m_tready;
  logic [7:0]   m_tdata;   // hit, zero fill

  time_window_skip_table_unit #(.ENTRIES(ENTRIES)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // table model
  logic [ID_W-1:0]   win_id    [ENTRIES];
  logic [TIME_W-1:0] win_start [ENTRIES];
  logic [TIME_W-1:0] win_end   [ENTRIES];

  logic [ID_W-1:0] id_pool [ID_POOL];
  logic            pending_hits [$];
  int              idle_pct;
  int              stall_pct;
  int              errors = 0;
  int              quiet_cycles = 0;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic skip_table_apply(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                            logic [TIME_W-1:0] ws, logic [TIME_W-1:0] we,
                                            logic [TIME_W-1:0] now);
    logic found;
    found = 1'b0;
    case (cmd)
      CMD_SET: begin
        if (ws != 0 && we != 0 && we > ws) begin
          found = 1'b1;
          for (int k = 0; k < ENTRIES; k++) begin
            if (win_id[k] == id || win_id[k] == 0 || k == ENTRIES - 1) begin
              win_id[k]    = id;
              win_start[k] = ws;
              win_end[k]   = we;
              break;
            end
          end
        end
      end
      CMD_CHECK: begin
        for (int k = 0; k < ENTRIES; k++)
          if (win_id[k] == id && now >= win_start[k] && now < win_end[k])
            found = 1'b1;
      end
      CMD_CLEAR: begin
        for (int k = 0; k < ENTRIES; k++) begin
          if (win_id[k] == id) begin
            win_id[k]    = '0;
            win_start[k] = '0;
            win_end[k]   = '0;
            found = 1'b1;
            break;
          end
        end
      end
      default: found = 1'b0;
    endcase
    return found;
  endfunction

  // drive one command word; expectation queued at the accepting edge
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                              logic [TIME_W-1:0] ws, logic [TIME_W-1:0] we,
                              logic [TIME_W-1:0] now, logic known, logic hit);
    logic predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, we, ws, id};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    predicted = skip_table_apply(cmd, id, ws, we, now);
    pending_hits.push_back(known ? hit : predicted);
  endtask

  task automatic send_random;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] ws, we, now, span;
    int pick, k;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, ENTRIES - 1);
    ws   = $urandom;
    we   = $urandom;
    now  = $urandom;
    id   = ($urandom_range(0, 99) < 5) ? $urandom : id_pool[$urandom_range(0, ID_POOL - 1)];
    if (pick < 40) begin
      cmd = CMD_SET;
      case ($urandom_range(0, 19))
        0:       ws = '0;
        1:       we = '0;
        2:       we = ws;
        3, 4:    ;  // fully random pair
        5:       begin ws = $urandom_range(1, 64); we = ws + $urandom_range(1, 64); end
        default: we = ws + $urandom_range(1, 5000);
      endcase
    end else if (pick < 75) begin
      cmd = CMD_CHECK;
      if ($urandom_range(0, 99) < 60) id = win_id[k];
      if ($urandom_range(0, 99) < 85) begin
        span = win_end[k] - win_start[k];
        if (span > 6000) span = 6000;
        now = win_start[k] + $urandom_range(0, span + 4) - 2;
      end
    end else if (pick < 93) begin
      cmd = CMD_CLEAR;
      if ($urandom_range(0, 99) < 50) id = win_id[k];
    end else begin
      cmd = CMD_UNUSED;
    end
    send_command(cmd, id, ws, we, now, 1'b0, 1'b0);
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else     m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_hits.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          if (m_tdata !== {7'b0, pending_hits[0]}) begin
            $display("%0t: hit mismatch, expected %h, actual %h", $time,
                     {7'b0, pending_hits[0]}, m_tdata);
            errors++;
          end
          void'(pending_hits.pop_front());
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_MAX);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_SET;
    idle_pct  = 0;
    stall_pct = 0;
    for (int k = 0; k < ENTRIES; k++) begin
      win_id[k]    = '0;
      win_start[k] = '0;
      win_end[k]   = '0;
    end
    id_pool[0] = '0;
    for (int k = 1; k < ID_POOL; k++) id_pool[k] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++)
      send_command(DIR_TABLE[r].cmd, DIR_TABLE[r].id, DIR_TABLE[r].ws, DIR_TABLE[r].we,
                   DIR_TABLE[r].now, DIR_TABLE[r].known, DIR_TABLE[r].hit);

    // phases: no idling, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 53 : (ph == 3) ? 20 : 0;
      stall_pct = (ph == 2) ? 53 : (ph == 3) ? 20 : 0;
      for (int n = 0; n < RAND_ITEMS / 4; n++) send_random();
    end
    s_tvalid <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else             $display("Regression FAIL");
    $finish;
  end

endmodule
